[hw/rtl/sspg_pkg.sv]
// shared types and constants for the step/direction pulse generator
// no dependencies; imported by the top level, the port checker and the testbench
`timescale 1ns / 1ps

package sspg_pkg;

    localparam int AXIS_COUNT    = 3;
    localparam int POSITION_BITS = 16;
    localparam int TIMER_BITS    = 20;

    localparam int OPCODE_BITS = 2;
    localparam int AXIS_BITS   = 2;
    localparam int AMOUNT_BITS = 17;
    localparam int SETUP_BITS  = 8;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    // signed width that holds position plus a signed step count
    localparam int SUM_BITS =
        ((POSITION_BITS > AMOUNT_BITS) ? POSITION_BITS : AMOUNT_BITS) + 2;

    localparam logic [POSITION_BITS-1:0] MAX_POSITION_RESET = POSITION_BITS'(10000);
    localparam logic [TIMER_BITS-1:0]    PULSE_HIGH_RESET   = TIMER_BITS'(1000);
    localparam logic [TIMER_BITS-1:0]    STEP_PERIOD_RESET  = TIMER_BITS'(2000);
    localparam logic [SETUP_BITS-1:0]    DIR_SETUP_RESET    = SETUP_BITS'(5);

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_SET  = 2'd2,
        OP_NOP  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SETUP = 2'd1,
        PH_HIGH  = 2'd2,
        PH_LOW   = 2'd3
    } phase_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MAX_POSITION = 8'd0,
        CFG_PULSE_HIGH   = 8'd1,
        CFG_STEP_PERIOD  = 8'd2,
        CFG_DIR_SETUP    = 8'd3
    } cfg_index_t;

endpackage

[hw/rtl/stepper_step_dir_pulse_generator.sv]
// step/direction pulse generator for three axes with soft position limits
// depends on sspg_pkg
`timescale 1ns / 1ps

// a request passes through the input register, then the result register
// one request per cycle unless the result is stalled; every request gives one result
// the whole update of one request sits between the input register and the result register
// reset: asynchronous, active low; axis positions and motion state cleared,
// configuration back to its default values, both registers empty

module stepper_step_dir_pulse_generator
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [sspg_pkg::OPCODE_BITS-1:0]      opcode,
    input  logic [sspg_pkg::AXIS_BITS-1:0]        axis,
    input  logic signed [sspg_pkg::AMOUNT_BITS-1:0] amount,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sspg_pkg::AXIS_COUNT-1:0]       step_pins,
    output logic [sspg_pkg::AXIS_COUNT-1:0]       dir_pins,
    output logic                                  busy_res,
    output logic                                  accepted,
    output logic [sspg_pkg::POSITION_BITS-1:0]    steps_left,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sspg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [sspg_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import sspg_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int TB = TIMER_BITS;

    // configuration
    logic [PB-1:0]         max_pos_reg;
    logic [TB-1:0]         pulse_high_reg;
    logic [TB-1:0]         step_period_reg;
    logic [SETUP_BITS-1:0] dir_setup_reg;

    // input register
    logic                        in_vld_reg;
    opcode_t                     in_op_reg;
    logic [AXIS_BITS-1:0]        in_axis_reg;
    logic signed [AMOUNT_BITS-1:0] in_amount_reg;

    // motion state
    logic [PB-1:0]         axis_pos_reg [AXIS_COUNT];
    logic [PB-1:0]         axis_pos_next [AXIS_COUNT];
    logic [AXIS_COUNT-1:0] dir_reg, dir_next;
    logic [AXIS_BITS-1:0]  active_reg, active_next;
    logic [PB-1:0]         target_reg, target_next;
    logic [PB-1:0]         remain_reg, remain_next;
    phase_t                phase_reg, phase_next;
    logic [TB-1:0]         timer_reg, timer_next;

    // result register
    logic                  out_vld_reg;
    logic [AXIS_COUNT-1:0] step_reg;
    logic [AXIS_COUNT-1:0] dirp_reg;
    logic                  busy_reg;
    logic                  acc_reg, acc_next;
    logic [PB-1:0]         left_reg;

    logic advance;
    logic axis_ok;
    logic [TB-1:0] high_time, low_time;
    logic [PB-1:0] cur_pos;
    logic signed [SUM_BITS-1:0] sum_target, lim_s;
    logic [AMOUNT_BITS-1:0] mag;
    logic [SUM_BITS-1:0] mv_steps;
    logic [PB-1:0] mv_target;
    logic [PB-1:0] set_value;
    logic fwd;

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pos_reg     <= MAX_POSITION_RESET;
            pulse_high_reg  <= PULSE_HIGH_RESET;
            step_period_reg <= STEP_PERIOD_RESET;
            dir_setup_reg   <= DIR_SETUP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_POSITION: max_pos_reg     <= cfg_data[PB-1:0];
                CFG_PULSE_HIGH:   pulse_high_reg  <= cfg_data[TB-1:0];
                CFG_STEP_PERIOD:  step_period_reg <= cfg_data[TB-1:0];
                CFG_DIR_SETUP:    dir_setup_reg   <= cfg_data[SETUP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_op_reg     <= opcode_t'(opcode);
            in_axis_reg   <= axis;
            in_amount_reg <= amount;
        end
    end

    // pulse timing, a zero high time counts as one tick
    always_comb
    begin
        high_time = (pulse_high_reg == '0) ? TB'(1) : pulse_high_reg;
        low_time  = (step_period_reg > pulse_high_reg) ?
                    (step_period_reg - pulse_high_reg) : TB'(1);
    end

    // move clamping against the soft limits
    always_comb
    begin
        axis_ok    = (32'(in_axis_reg) < AXIS_COUNT);
        cur_pos    = axis_ok ? axis_pos_reg[in_axis_reg] : '0;
        fwd        = !in_amount_reg[AMOUNT_BITS-1] && (in_amount_reg != '0);
        mag        = in_amount_reg[AMOUNT_BITS-1] ? (~in_amount_reg + 1'b1) : in_amount_reg;
        sum_target = $signed({{(SUM_BITS-PB){1'b0}}, cur_pos})
                   + $signed({{(SUM_BITS-AMOUNT_BITS){in_amount_reg[AMOUNT_BITS-1]}},
                              in_amount_reg});
        lim_s      = $signed({{(SUM_BITS-PB){1'b0}}, max_pos_reg});
        if (sum_target > lim_s)
        begin
            mv_target = max_pos_reg;
            mv_steps  = (cur_pos > max_pos_reg) ? '0 :
                        {{(SUM_BITS-PB){1'b0}}, max_pos_reg - cur_pos};
        end
        else if (sum_target < 0)
        begin
            mv_target = '0;
            mv_steps  = {{(SUM_BITS-PB){1'b0}}, cur_pos};
        end
        else
        begin
            mv_target = sum_target[PB-1:0];
            mv_steps  = {{(SUM_BITS-AMOUNT_BITS){1'b0}}, mag};
        end

        // set position saturates to 0..max_position
        if (in_amount_reg[AMOUNT_BITS-1])
            set_value = '0;
        else if ($signed({{(SUM_BITS-AMOUNT_BITS){1'b0}}, in_amount_reg}) > lim_s)
            set_value = max_pos_reg;
        else
            set_value = in_amount_reg[PB-1:0];
    end

    always_comb
    begin
        axis_pos_next = axis_pos_reg;
        dir_next      = dir_reg;
        active_next   = active_reg;
        target_next   = target_reg;
        remain_next   = remain_reg;
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        acc_next      = 1'b0;

        unique case (in_op_reg)
            OP_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (timer_reg > TB'(1))
                        timer_next = timer_reg - 1'b1;
                    else
                    begin
                        unique case (phase_reg)
                            PH_SETUP:
                            begin
                                phase_next = PH_HIGH;
                                timer_next = high_time;
                            end
                            PH_HIGH:
                            begin
                                if (remain_reg != '0)
                                    remain_next = remain_reg - 1'b1;
                                phase_next = PH_LOW;
                                timer_next = low_time;
                            end
                            PH_LOW:
                            begin
                                if (remain_reg == '0)
                                begin
                                    // move done, position takes the target
                                    if (32'(active_reg) < AXIS_COUNT)
                                        axis_pos_next[active_reg] = target_reg;
                                    phase_next = PH_IDLE;
                                    timer_next = '0;
                                end
                                else
                                begin
                                    phase_next = PH_HIGH;
                                    timer_next = high_time;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            OP_MOVE:
            begin
                if (phase_reg == PH_IDLE && axis_ok)
                begin
                    acc_next = 1'b1;
                    if (in_amount_reg == '0 || mv_steps == '0)
                        axis_pos_next[in_axis_reg] = mv_target;
                    else
                    begin
                        dir_next[in_axis_reg] = fwd;
                        active_next = in_axis_reg;
                        target_next = mv_target;
                        remain_next = mv_steps[PB-1:0];
                        if (dir_setup_reg == '0)
                        begin
                            phase_next = PH_HIGH;
                            timer_next = high_time;
                        end
                        else
                        begin
                            phase_next = PH_SETUP;
                            timer_next = {{(TB-SETUP_BITS){1'b0}}, dir_setup_reg};
                        end
                    end
                end
            end
            OP_SET:
            begin
                if (axis_ok)
                begin
                    acc_next = 1'b1;
                    axis_pos_next[in_axis_reg] = set_value;
                end
            end
            OP_NOP: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
                axis_pos_reg[i] <= '0;
            dir_reg     <= '0;
            active_reg  <= '0;
            target_reg  <= '0;
            remain_reg  <= '0;
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                axis_pos_reg <= axis_pos_next;
                dir_reg      <= dir_next;
                active_reg   <= active_next;
                target_reg   <= target_next;
                remain_reg   <= remain_next;
                phase_reg    <= phase_next;
                timer_reg    <= timer_next;
                out_vld_reg  <= 1'b1;
            end
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            step_reg <= (phase_next == PH_HIGH && 32'(active_next) < AXIS_COUNT) ?
                        (AXIS_COUNT'(1) << active_next) : '0;
            dirp_reg <= dir_next;
            busy_reg <= (phase_next != PH_IDLE);
            acc_reg  <= acc_next;
            left_reg <= (phase_next != PH_IDLE) ? remain_next : '0;
        end
    end

    assign out_valid  = out_vld_reg;
    assign step_pins  = step_reg;
    assign dir_pins   = dirp_reg;
    assign busy_res   = busy_reg;
    assign accepted   = acc_reg;
    assign steps_left = left_reg;

endmodule

[hw/rtl/sspg_port_checker.sv]
// port-level checks on the step/direction pulse generator results
// depends on sspg_pkg; bound to stepper_step_dir_pulse_generator
`timescale 1ns / 1ps

module sspg_port_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [sspg_pkg::AXIS_COUNT-1:0]     step_pins,
    input logic                                busy_res,
    input logic [sspg_pkg::POSITION_BITS-1:0]  steps_left
);
    import sspg_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(step_pins) && $stable(steps_left))
        else $error("stalled result changed");

    // at most one axis pulses at a time
    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(step_pins))
        else $error("more than one step pin high");

    a_pulse_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (step_pins != '0) |-> busy_res)
        else $error("step pulse while idle");

    a_idle_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> steps_left == '0)
        else $error("steps left while idle");

endmodule

bind stepper_step_dir_pulse_generator sspg_port_checker u_sspg_port_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .step_pins  (step_pins),
    .busy_res   (busy_res),
    .steps_left (steps_left)
);

[tb/sv/tb_stepper_step_dir_pulse_generator.sv]
// self-checking bench for the three-axis step/direction pulse generator
// predicts every pin snapshot from its own copy of the motion state; needs sspg_pkg and the top level
`timescale 1ns / 1ps

module tb_stepper_step_dir_pulse_generator;

    import sspg_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    typedef struct {
        logic [AXIS_COUNT-1:0]    step;
        logic [AXIS_COUNT-1:0]    dir;
        logic                     busy;
        logic                     acc;
        logic [POSITION_BITS-1:0] left;
    } pin_snapshot_t;

    class pulse_train_checker;
        logic [POSITION_BITS-1:0] max_pos;
        logic [TIMER_BITS-1:0]    hi_ticks;
        logic [TIMER_BITS-1:0]    period_ticks;
        logic [SETUP_BITS-1:0]    setup_ticks;

        logic [POSITION_BITS-1:0] pos [AXIS_COUNT];
        logic [AXIS_COUNT-1:0]    dir_lv;
        logic [AXIS_BITS-1:0]     act_axis;
        logic [POSITION_BITS-1:0] target_pos;
        logic [POSITION_BITS-1:0] steps_rem;
        phase_t                   ph;
        logic [TIMER_BITS-1:0]    ph_timer;

        pin_snapshot_t expected_pins [$];
        int errors;

        function new();
            max_pos      = MAX_POSITION_RESET;
            hi_ticks     = PULSE_HIGH_RESET;
            period_ticks = STEP_PERIOD_RESET;
            setup_ticks  = DIR_SETUP_RESET;
            foreach (pos[i])
                pos[i] = '0;
            dir_lv     = '0;
            act_axis   = '0;
            target_pos = '0;
            steps_rem  = '0;
            ph         = PH_IDLE;
            ph_timer   = '0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        function bit busy();
            return ph != PH_IDLE;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
            case (cfg_index_t'(idx))
                CFG_MAX_POSITION: max_pos      = d[POSITION_BITS-1:0];
                CFG_PULSE_HIGH:   hi_ticks     = d[TIMER_BITS-1:0];
                CFG_STEP_PERIOD:  period_ticks = d[TIMER_BITS-1:0];
                CFG_DIR_SETUP:    setup_ticks  = d[SETUP_BITS-1:0];
                default: ;
            endcase
        endfunction

        // a zero high time still gives a one-tick pulse
        function logic [TIMER_BITS-1:0] pulse_len();
            return (hi_ticks == 0) ? TIMER_BITS'(1) : hi_ticks;
        endfunction

        // clamped step count of a move, target position returned through tgt
        function int move_span(int ax, int a, output int tgt);
            int p;
            int lim;
            int s;
            tgt = 0;
            if (ax >= AXIS_COUNT)
                return 0;
            p   = int'(pos[ax]);
            lim = int'(max_pos);
            s   = (a > 0) ? a : -a;
            tgt = p + a;
            if (tgt > lim)
            begin
                tgt = lim;
                s   = lim - p;
                if (s < 0)
                    s = 0;
            end
            else if (tgt < 0)
            begin
                tgt = 0;
                s   = p;
            end
            return s;
        endfunction

        function void note_request(logic [OPCODE_BITS-1:0] op, logic [AXIS_BITS-1:0] ax,
                                   logic signed [AMOUNT_BITS-1:0] amt);
            int a;
            int lim;
            int tgt;
            int span;
            bit took;
            pin_snapshot_t e;
            a    = int'(amt);
            lim  = int'(max_pos);
            took = 0;
            case (opcode_t'(op))
                OP_TICK:
                    if (ph != PH_IDLE)
                    begin
                        if (ph_timer > 1)
                            ph_timer--;
                        else
                            case (ph)
                                PH_SETUP:
                                begin
                                    ph       = PH_HIGH;
                                    ph_timer = pulse_len();
                                end
                                PH_HIGH:
                                begin
                                    if (steps_rem > 0)
                                        steps_rem--;
                                    ph       = PH_LOW;
                                    ph_timer = (period_ticks > hi_ticks) ?
                                               period_ticks - hi_ticks : TIMER_BITS'(1);
                                end
                                default:
                                    if (steps_rem == 0)
                                    begin
                                        pos[act_axis] = target_pos;
                                        ph            = PH_IDLE;
                                        ph_timer      = '0;
                                    end
                                    else
                                    begin
                                        ph       = PH_HIGH;
                                        ph_timer = pulse_len();
                                    end
                            endcase
                    end
                OP_MOVE:
                    if (ph == PH_IDLE && ax < AXIS_COUNT)
                    begin
                        took = 1;
                        span = move_span(int'(ax), a, tgt);
                        if (span == 0)
                            pos[ax] = POSITION_BITS'(tgt);
                        else
                        begin
                            dir_lv[ax] = (a > 0);
                            act_axis   = ax;
                            target_pos = POSITION_BITS'(tgt);
                            steps_rem  = POSITION_BITS'(span);
                            if (setup_ticks == 0)
                            begin
                                ph       = PH_HIGH;
                                ph_timer = pulse_len();
                            end
                            else
                            begin
                                ph       = PH_SETUP;
                                ph_timer = TIMER_BITS'(setup_ticks);
                            end
                        end
                    end
                OP_SET:
                    if (ax < AXIS_COUNT)
                    begin
                        took    = 1;
                        pos[ax] = POSITION_BITS'((a < 0) ? 0 : (a > lim) ? lim : a);
                    end
                default: ;
            endcase
            e.step = (ph == PH_HIGH) ? AXIS_COUNT'(1 << act_axis) : '0;
            e.dir  = dir_lv;
            e.busy = (ph != PH_IDLE);
            e.acc  = took;
            e.left = e.busy ? steps_rem : '0;
            expected_pins.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pins(logic [AXIS_COUNT-1:0] s, logic [AXIS_COUNT-1:0] d,
                                 logic b, logic acc, logic [POSITION_BITS-1:0] left);
            pin_snapshot_t e;
            if (expected_pins.size() == 0)
            begin
                $display("%0t: result expected none actual step %0h dir %0h busy %0b %s %0b %s %0d",
                         $time, s, d, b, "acc", acc, "left", left);
                errors++;
                return;
            end
            e = expected_pins.pop_front();
            compare_field("step_pins", 32'(e.step), 32'(s));
            compare_field("dir_pins", 32'(e.dir), 32'(d));
            compare_field("busy_res", 32'(e.busy), 32'(b));
            compare_field("accepted", 32'(e.acc), 32'(acc));
            compare_field("steps_left", 32'(e.left), 32'(left));
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [OPCODE_BITS-1:0] opcode = '0;
    logic [AXIS_BITS-1:0] axis = '0;
    logic signed [AMOUNT_BITS-1:0] amount = '0;
    logic out_valid;
    logic out_stall = 0;
    logic [AXIS_COUNT-1:0] step_pins;
    logic [AXIS_COUNT-1:0] dir_pins;
    logic busy_res;
    logic accepted;
    logic [POSITION_BITS-1:0] steps_left;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    pulse_train_checker chk = new();
    int idle_mode = 0;
    int sent = 0;
    int quiet_cycles = 0;

    stepper_step_dir_pulse_generator DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .axis       (axis),
        .amount     (amount),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .step_pins  (step_pins),
        .dir_pins   (dir_pins),
        .busy_res   (busy_res),
        .accepted   (accepted),
        .steps_left (steps_left),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        case (idle_mode)
            0:       out_stall <= ($urandom_range(0, 99) < 48);
            1:       out_stall <= ($urandom_range(0, 99) < 21);
            default: out_stall <= 1'b0;
        endcase
    end

    // request noted before the result check so a result that came out with its own request would still line up
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            chk.note_request(opcode, axis, amount);
        if (out_valid && !out_stall)
            chk.check_pins(step_pins, dir_pins, busy_res, accepted, steps_left);
        if (cfg_valid && cfg_ready)
            chk.write_reg(cfg_index, cfg_data);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send(opcode_t op, int ax, int amt);
        sent++;
        idle_mode = (sent < 650) ? 0 : (sent < 1300) ? 1 : 2;
        while ($urandom_range(0, 99) < ((idle_mode == 0) ? 21 : (idle_mode == 1) ? 48 : 0))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        axis     <= AXIS_BITS'(ax);
        amount   <= AMOUNT_BITS'(amt);
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain_motion();
        while (chk.busy())
            send(OP_TICK, int'($urandom_range(0, 3)), $urandom);
    endtask

    task automatic write_setting(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] d);
        while (chk.pending() != 0)
            @(negedge clk);
        // let the result register settle before touching the settings
        repeat (4)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(logic [CFG_DATA_BITS-1:0] mx, logic [CFG_DATA_BITS-1:0] hi,
                                  logic [CFG_DATA_BITS-1:0] per, logic [CFG_DATA_BITS-1:0] setup);
        drain_motion();
        in_valid <= 1'b0;
        write_setting(CFG_MAX_POSITION, mx);
        write_setting(CFG_PULSE_HIGH, hi);
        write_setting(CFG_STEP_PERIOD, per);
        write_setting(CFG_DIR_SETUP, setup);
    endtask

    // mostly ticks so moves run to completion; moves longer than cap are made zero-length
    task automatic random_request(int cap);
        int r;
        int amt;
        int tgt;
        logic [AXIS_BITS-1:0] ax;
        logic signed [AMOUNT_BITS-1:0] raw;
        opcode_t op;
        r   = $urandom_range(0, 99);
        op  = (r < 55) ? OP_TICK : (r < 80) ? OP_MOVE : (r < 93) ? OP_SET : OP_NOP;
        ax  = ($urandom_range(0, 9) == 0) ? 2'd3 : AXIS_BITS'($urandom_range(0, 2));
        raw = AMOUNT_BITS'($urandom);
        amt = ($urandom_range(0, 3) == 0) ? int'(raw) : int'($urandom_range(0, 80)) - 40;
        if (op == OP_MOVE && chk.move_span(int'(ax), amt, tgt) > cap)
            amt = 0;
        send(op, int'(ax), amt);
    endtask

    task automatic run_phase(logic [CFG_DATA_BITS-1:0] mx, logic [CFG_DATA_BITS-1:0] hi,
                             logic [CFG_DATA_BITS-1:0] per, logic [CFG_DATA_BITS-1:0] setup,
                             int count, int cap);
        apply_settings(mx, hi, per, setup);
        repeat (count)
            random_request(cap);
    endtask

    initial
    begin
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default settings: saturation, refused axis, ignored opcode, zero-length moves
        send(OP_SET, 0, -5);
        send(OP_SET, 1, 65535);
        send(OP_SET, 2, -65536);
        send(OP_MOVE, 3, 5);
        send(OP_SET, 3, 100);
        send(OP_NOP, 2, -1);
        send(OP_MOVE, 0, 0);
        send(OP_MOVE, 1, 50);
        send(OP_TICK, 0, 0);

        // zero high time and zero setup; y now sits above the new limit
        apply_settings(20, 0, 2, 0);
        send(OP_MOVE, 1, 7);
        send(OP_MOVE, 0, 2);
        send(OP_MOVE, 1, -2);
        send(OP_SET, 0, 9);
        drain_motion();
        send(OP_MOVE, 2, -4);
        send(OP_SET, 1, 2);
        send(OP_MOVE, 1, -65536);
        drain_motion();

        run_phase(40, 1, 1, 0, 350, 64);
        run_phase(25, 3, 7, 2, 350, 64);
        run_phase(65535, 2, 5, 1, 350, 40);
        run_phase(12, 1, 2, 255, 200, 64);
        run_phase(0, 1048575, 1048575, 7, 200, 0);
        run_phase(30, 2, 2, 3, 300, 64);
        // upper data bits are dropped by the register widths; motion here never ends
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF00, 200, 65535);

        in_valid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
        repeat (6)
            @(posedge clk);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
